[sv/dvf_pkg.sv]
// Shared types and constants for the distinct value filter.
`timescale 1ns / 1ps

package dvf_pkg;

   // Default number of table entries
   localparam int SET_DEPTH_DEFAULT = 128;

   // Fixed field widths
   localparam int VALUE_W     = 32;
   localparam int COUNT_OUT_W = 8;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } fsm_state_type;

   // Table access strobes from the controller to the memory
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctrl_type;

endpackage

[sv/dvf_table_mem.sv]
// Single-port-write, single-port-read table memory with registered read data.
`timescale 1ns / 1ps

module dvf_table_mem #(
   parameter int DEPTH = dvf_pkg::SET_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  dvf_pkg::mem_ctrl_type      ctrl,
   input  logic [AW-1:0]              rd_addr,
   input  logic [AW-1:0]              wr_addr,
   input  logic [dvf_pkg::VALUE_W-1:0] wr_data,
   output logic [dvf_pkg::VALUE_W-1:0] rd_data
);

   logic [dvf_pkg::VALUE_W-1:0] mem_ff [DEPTH];

   // Write one entry
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read one entry; the read data is registered
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[sv/dvf_search_ctrl.sv]
// Linear search controller: scans the table, appends new values, builds the result.
`timescale 1ns / 1ps

module dvf_search_ctrl #(
   parameter int SET_DEPTH = dvf_pkg::SET_DEPTH_DEFAULT,
   parameter int AW        = $clog2(SET_DEPTH),
   parameter int CW        = $clog2(SET_DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [dvf_pkg::VALUE_W-1:0] req_value,
   input  logic                              req_last_of_sequence,
   output dvf_pkg::mem_ctrl_type             mem_ctrl,
   output logic [AW-1:0]                     mem_rd_addr,
   output logic [AW-1:0]                     mem_wr_addr,
   output logic [dvf_pkg::VALUE_W-1:0]       mem_wr_data,
   input  logic [dvf_pkg::VALUE_W-1:0]       mem_rd_data,
   output logic                              rsp_strobe,
   output logic signed [dvf_pkg::VALUE_W-1:0] rsp_echo_value,
   output logic                              rsp_is_new,
   output logic [dvf_pkg::COUNT_OUT_W-1:0]   rsp_distinct_count,
   output logic                              rsp_overflow,
   output logic                              rsp_sequence_done
);

   localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

   dvf_pkg::fsm_state_type state_ff, state_in;

   logic [dvf_pkg::VALUE_W-1:0]     value_ff, value_in;
   logic                            last_ff, last_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic                            pend_ff, pend_in;
   logic                            found_ff, found_in;
   logic                            strobe_ff, strobe_in;
   logic [dvf_pkg::VALUE_W-1:0]     echo_ff, echo_in;
   logic                            new_ff, new_in;
   logic [dvf_pkg::COUNT_OUT_W-1:0] dcount_ff, dcount_in;
   logic                            ovf_ff, ovf_in;
   logic                            done_ff, done_in;

   logic          accept;
   logic          issue;
   logic          hit;
   logic          scan_end;
   logic          full;
   logic          do_append;
   logic [CW-1:0] count_next;

   // Scan conditions
   always_comb begin
      accept     = start && (state_ff == dvf_pkg::ST_IDLE);
      issue      = idx_ff < count_ff;
      hit        = pend_ff && (mem_rd_data == value_ff);
      scan_end   = hit || (!issue && !pend_ff);
      full       = count_ff == DEPTH_C;
      do_append  = (state_ff == dvf_pkg::ST_RESP) && !found_ff && !full;
      count_next = count_ff + CW'(do_append);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dvf_pkg::ST_IDLE: begin
            if (accept) state_in = dvf_pkg::ST_SCAN;
         end
         dvf_pkg::ST_SCAN: begin
            if (scan_end) state_in = dvf_pkg::ST_RESP;
         end
         dvf_pkg::ST_RESP: state_in = dvf_pkg::ST_IDLE;
         default:          state_in = dvf_pkg::ST_IDLE;
      endcase
   end

   // Outputs toward the memory and the handshake
   always_comb begin
      busy           = state_ff != dvf_pkg::ST_IDLE;
      mem_ctrl.rd_en = (state_ff == dvf_pkg::ST_SCAN) && issue && !hit;
      mem_ctrl.wr_en = do_append;
      mem_rd_addr    = idx_ff[AW-1:0];
      mem_wr_addr    = count_ff[AW-1:0];
      mem_wr_data    = value_ff;
   end

   // Datapath next values
   always_comb begin
      value_in  = value_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      pend_in   = 1'b0;
      found_in  = found_ff;
      strobe_in = state_ff == dvf_pkg::ST_RESP;
      echo_in   = echo_ff;
      new_in    = new_ff;
      dcount_in = dcount_ff;
      ovf_in    = ovf_ff;
      done_in   = done_ff;
      case (state_ff)
         dvf_pkg::ST_IDLE: begin
            // Latch the item and restart the scan
            if (accept) begin
               value_in = req_value;
               last_in  = req_last_of_sequence;
               idx_in   = '0;
               found_in = 1'b0;
            end
         end
         dvf_pkg::ST_SCAN: begin
            // Advance the read pointer until a match or the end of the stored entries
            if (scan_end) begin
               found_in = hit;
            end else begin
               pend_in = issue;
               if (issue) idx_in = idx_ff + CW'(1);
            end
         end
         dvf_pkg::ST_RESP: begin
            // Register the result and drop the table at end of sequence
            echo_in   = value_ff;
            new_in    = !found_ff;
            ovf_in    = !found_ff && full;
            dcount_in = dvf_pkg::COUNT_OUT_W'(count_next);
            done_in   = last_ff;
            count_in  = last_ff ? '0 : count_next;
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dvf_pkg::ST_IDLE;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      last_ff   <= last_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      echo_ff   <= echo_in;
      new_ff    <= new_in;
      dcount_ff <= dcount_in;
      ovf_ff    <= ovf_in;
      done_ff   <= done_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_echo_value     = echo_ff;
   assign rsp_is_new         = new_ff;
   assign rsp_distinct_count = dcount_ff;
   assign rsp_overflow       = ovf_ff;
   assign rsp_sequence_done  = done_ff;

   // Count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("stored count above table depth");

   // Append only into a free entry
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      mem_ctrl.wr_en |-> (count_ff < DEPTH_C))
      else $error("table write while full");

   // Reads stay inside the stored entries
   a_read_valid: assert property (@(posedge clock) disable iff (reset)
      mem_ctrl.rd_en |-> (idx_ff < count_ff))
      else $error("read of an unstored entry");

   // Every finished item gives one result strobe in the next cycle
   a_resp_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dvf_pkg::ST_RESP) |=> (rsp_strobe && !busy))
      else $error("result strobe missing after response");

   // Overflow only for a new value
   a_ovf_new: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_overflow |-> rsp_is_new)
      else $error("overflow flagged for a repeated value");

endmodule

[sv/distinct_value_filter_core.sv]
// Top level of the distinct value filter: controller plus table memory.
`timescale 1ns / 1ps
//
// Usage:
//   Drive req_value and req_last_of_sequence with start high; the item is
//   taken at a clock edge where start is high and busy is low. busy stays
//   high while the item is searched and resolved.
//   Each item gives exactly one result, shown for one cycle with rsp_strobe
//   high: the value echoed, whether it was new, the distinct count after it,
//   an overflow flag when a new value found the table full, and a copy of
//   the last flag. The receiver cannot stall; results must be taken.
// Search and handshake:
//   After accept the controller scans the stored entries in order, one
//   entry per cycle from the read port of the table memory, and stops at
//   the first match or after the last stored entry; with the set empty no
//   read is made. busy drops in the cycle the strobe shows, so a new item
//   may be accepted then; no new item is taken before the last one has
//   given its result.
// Reset:
//   Synchronous reset empties the set and clears the controller; table
//   contents are not cleared and need no clearing pass. After an item
//   marked last of sequence the set is emptied for the next sequence.
//
module distinct_value_filter_core #(
   parameter int SET_DEPTH = dvf_pkg::SET_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [dvf_pkg::VALUE_W-1:0] req_value,
   input  logic                              req_last_of_sequence,
   output logic                              rsp_strobe,
   output logic signed [dvf_pkg::VALUE_W-1:0] rsp_echo_value,
   output logic                              rsp_is_new,
   output logic [dvf_pkg::COUNT_OUT_W-1:0]   rsp_distinct_count,
   output logic                              rsp_overflow,
   output logic                              rsp_sequence_done
);

   localparam int AW = $clog2(SET_DEPTH);
   localparam int CW = $clog2(SET_DEPTH + 1);

   dvf_pkg::mem_ctrl_type       mem_ctrl;
   logic [AW-1:0]               mem_rd_addr;
   logic [AW-1:0]               mem_wr_addr;
   logic [dvf_pkg::VALUE_W-1:0] mem_wr_data;
   logic [dvf_pkg::VALUE_W-1:0] mem_rd_data;

   // Search and append sequencer
   dvf_search_ctrl #(
      .SET_DEPTH (SET_DEPTH),
      .AW        (AW),
      .CW        (CW)
   ) u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_value            (req_value),
      .req_last_of_sequence (req_last_of_sequence),
      .mem_ctrl             (mem_ctrl),
      .mem_rd_addr          (mem_rd_addr),
      .mem_wr_addr          (mem_wr_addr),
      .mem_wr_data          (mem_wr_data),
      .mem_rd_data          (mem_rd_data),
      .rsp_strobe           (rsp_strobe),
      .rsp_echo_value       (rsp_echo_value),
      .rsp_is_new           (rsp_is_new),
      .rsp_distinct_count   (rsp_distinct_count),
      .rsp_overflow         (rsp_overflow),
      .rsp_sequence_done    (rsp_sequence_done)
   );

   // Distinct value storage
   dvf_table_mem #(
      .DEPTH (SET_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .ctrl    (mem_ctrl),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule
